@@ rtl/core/wavp_pkg.sv @@
// shared types and codes for the wav header parser stream
// no dependencies; used by wavp_parser, wavp_out_fifo and the top level
package wavp_pkg;

	// result kinds
	localparam logic [1:0] KIND_DESC  = 2'd0;
	localparam logic [1:0] KIND_DATA  = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// error codes
	localparam logic [2:0] ERR_NOT_RIFF = 3'd0;
	localparam logic [2:0] ERR_NOT_WAVE = 3'd1;
	localparam logic [2:0] ERR_NO_FMT   = 3'd2;
	localparam logic [2:0] ERR_FORMAT   = 3'd3;
	localparam logic [2:0] ERR_CHANNELS = 3'd4;
	localparam logic [2:0] ERR_BITS     = 3'd5;
	localparam logic [2:0] ERR_ALIGN    = 3'd6;
	localparam logic [2:0] ERR_NO_DATA  = 3'd7;

	// chunk tags as little-endian words
	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	localparam logic [31:0] FMT_STD_LEN = 32'd16;

	localparam int TDATA_W = 80;

	typedef struct packed {
		logic        valid;
		logic [1:0]  kind;
		logic [2:0]  err_code;
		logic [1:0]  sample_type;
		logic [31:0] rate_hz;
		logic [31:0] frames_total;
		logic [7:0]  sample_byte;
		logic        last_data;
	} wavp_result_t;

	typedef struct packed {
		logic full;
		logic empty;
	} wavp_buf_stat_t;

endpackage

@@ rtl/core/wav_header_parser_stream.sv @@
// top level of the wav header parser stream: input register, parser, result buffer
// depends on wavp_pkg, wavp_parser and wavp_out_fifo
//
// usage
// - slave channel s_*: one file byte per transaction; s_tuser marks the first
//   byte of a file (restarts the parser), s_tlast marks the final byte
// - master channel m_*: at most one result per input byte; m_tuser is the
//   result kind (descriptor, data byte, error), m_tlast marks the last data byte
// - bytes seen before any start of file are dropped without a result
// - result path: a byte is held in the input register, parsed, and its result is
//   written into the result buffer; m_* is driven from the buffer head
// - throughput: one byte per cycle while the result buffer has room; the parser state
//   update is a single pass of combinational logic between the input register and the result buffer
// - reset: parser waits for a start of file, both buffers empty
// - when the receiver stalls, the two-entry result buffer fills, then the input
//   register holds its byte and s_tready drops; no transaction is lost
module wav_header_parser_stream (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [7:0]                   s_tdata,  // [7:0] data_byte
	input  logic                         s_tuser,  // [0] start_of_file
	input  logic                         s_tlast,  // end_of_file
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// [2:0] error_code, [4:3] sample_type, [36:5] rate_hz,
	// [68:37] frames_total, [76:69] sample_byte, [79:77] zero
	output logic [wavp_pkg::TDATA_W-1:0] m_tdata,
	output logic [1:0]                   m_tuser,  // [1:0] result_kind
	output logic                         m_tlast   // last_data
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       sof_s1;
	logic       eof_s1;

	logic                     take;
	logic                     s_hs;
	wavp_pkg::wavp_result_t   res;
	wavp_pkg::wavp_result_t   head;
	wavp_pkg::wavp_buf_stat_t buf_stat;

	// the held byte is parsed once the result buffer has room
	assign take     = valid_s1 && !buf_stat.full;
	assign s_tready = !valid_s1 || !buf_stat.full;
	assign s_hs     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_hs) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_hs) begin
			byte_s1 <= s_tdata;
			sof_s1  <= s_tuser;
			eof_s1  <= s_tlast;
		end
	end

	wavp_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.data_byte     (byte_s1),
		.start_of_file (sof_s1),
		.end_of_file   (eof_s1),
		.result        (res)
	);

	wavp_out_fifo u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res),
		.pop    (m_tready),
		.head   (head),
		.stat   (buf_stat)
	);

	// output channel straight from the buffer head
	assign m_tvalid = !buf_stat.empty;
	assign m_tuser  = head.kind;
	assign m_tlast  = head.last_data;
	assign m_tdata  = {3'b000, head.sample_byte, head.frames_total, head.rate_hz,
	                   head.sample_type, head.err_code};

	// a byte held back by a full buffer stays in the input register
	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && buf_stat.full) |=> (valid_s1 && $stable(byte_s1)))
		else $error("input byte lost while result buffer full");

	// a full buffer stays full until a result leaves
	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(buf_stat.full && !m_tready) |=> buf_stat.full)
		else $error("result buffer drained without a transaction");

	// results are only produced for bytes actually taken
	a_push_on_take: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (take && !buf_stat.full))
		else $error("result pushed without a taken byte");

	// m_tvalid only drops after a completed transaction
	a_valid_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(m_tvalid) |-> $past(m_tready))
		else $error("result vanished without a transaction");

endmodule

@@ rtl/core/wavp_parser.sv @@
// byte-wise riff/wave header parser: state registers and next-state logic
// depends on wavp_pkg
module wavp_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  take,
	input  logic [7:0]            data_byte,
	input  logic                  start_of_file,
	input  logic                  end_of_file,
	output wavp_pkg::wavp_result_t result
);

	localparam logic [3:0] PH_IDLE       = 4'd0;
	localparam logic [3:0] PH_RIFF_TAG   = 4'd1;
	localparam logic [3:0] PH_RIFF_SIZE  = 4'd2;
	localparam logic [3:0] PH_WAVE_TAG   = 4'd3;
	localparam logic [3:0] PH_FMT_TAG    = 4'd4;
	localparam logic [3:0] PH_FMT_SIZE   = 4'd5;
	localparam logic [3:0] PH_FMT_BODY   = 4'd6;
	localparam logic [3:0] PH_FMT_SKIP   = 4'd7;
	localparam logic [3:0] PH_CHUNK_ID   = 4'd8;
	localparam logic [3:0] PH_DATA_SIZE  = 4'd9;
	localparam logic [3:0] PH_OTHER_SIZE = 4'd10;
	localparam logic [3:0] PH_CHUNK_SKIP = 4'd11;
	localparam logic [3:0] PH_DATA       = 4'd12;
	localparam logic [3:0] PH_DONE       = 4'd13;

	logic [3:0]  phase_q, phase_n;
	logic [3:0]  idx_q, idx_n;
	logic [31:0] shift_q, shift_n;
	logic [31:0] skip_q, skip_n;
	logic        stereo_q, stereo_n;
	logic        wide_q, wide_n;
	logic [31:0] rate_q, rate_n;
	logic [31:0] left_q, left_n;

	always_comb begin
		logic [3:0]  ph;
		logic [3:0]  idx;
		logic [31:0] fs;
		logic [31:0] skip;
		logic        stereo;
		logic        wide;
		logic [31:0] rate;
		logic [31:0] left;
		logic [31:0] fs_sh;
		logic        word_done;
		logic [3:0]  idx_inc;
		logic [15:0] hi_word;
		logic [15:0] exp_align;
		logic [31:0] frames;
		logic [31:0] whole;
		logic [31:0] skip_dec;
		logic [31:0] left_dec;
		logic        err_hit;
		logic [2:0]  err_code;
		logic        desc_hit;
		logic        data_hit;
		logic        data_last;

		// start of file restarts the parser before the byte is handled
		ph     = start_of_file ? PH_RIFF_TAG : phase_q;
		idx    = start_of_file ? 4'd0 : idx_q;
		fs     = start_of_file ? 32'd0 : shift_q;
		skip   = start_of_file ? 32'd0 : skip_q;
		stereo = start_of_file ? 1'b0 : stereo_q;
		wide   = start_of_file ? 1'b0 : wide_q;
		rate   = start_of_file ? 32'd0 : rate_q;
		left   = start_of_file ? 32'd0 : left_q;

		fs_sh     = {data_byte, fs[31:8]};
		word_done = (idx == 4'd3);
		idx_inc   = idx + 4'd1;
		hi_word   = fs_sh[31:16];
		exp_align = (hi_word == 16'd16) ? (stereo ? 16'd4 : 16'd2)
		                                : (stereo ? 16'd2 : 16'd1);
		skip_dec  = skip - 32'd1;
		left_dec  = left - 32'd1;
		// block align is 1, 2 or 4, so the division is a shift
		unique case ({stereo, wide}) inside
			2'b00: frames = fs_sh;
			2'b01, 2'b10: frames = {1'b0, fs_sh[31:1]};
			default: frames = {2'b00, fs_sh[31:2]};
		endcase
		unique case ({stereo, wide}) inside
			2'b00: whole = fs_sh;
			2'b01, 2'b10: whole = {fs_sh[31:1], 1'b0};
			default: whole = {fs_sh[31:2], 2'b00};
		endcase

		phase_n  = ph;
		idx_n    = idx;
		shift_n  = fs;
		skip_n   = skip;
		stereo_n = stereo;
		wide_n   = wide;
		rate_n   = rate;
		left_n   = left;
		err_hit  = 1'b0;
		err_code = wavp_pkg::ERR_NOT_RIFF;
		desc_hit = 1'b0;
		data_hit = 1'b0;
		data_last = 1'b0;

		unique case (ph) inside
			PH_RIFF_TAG, PH_WAVE_TAG, PH_FMT_TAG, PH_RIFF_SIZE, PH_FMT_SIZE,
			PH_CHUNK_ID, PH_OTHER_SIZE, PH_DATA_SIZE: begin
				shift_n = fs_sh;
				idx_n   = word_done ? 4'd0 : idx_inc;
				if (word_done) begin
					case (ph)
						PH_RIFF_TAG: begin
							if (fs_sh != wavp_pkg::TAG_RIFF) begin
								err_hit  = 1'b1;
								err_code = wavp_pkg::ERR_NOT_RIFF;
							end else begin
								phase_n = PH_RIFF_SIZE;
							end
						end
						PH_WAVE_TAG: begin
							if (fs_sh != wavp_pkg::TAG_WAVE) begin
								err_hit  = 1'b1;
								err_code = wavp_pkg::ERR_NOT_WAVE;
							end else begin
								phase_n = PH_FMT_TAG;
							end
						end
						PH_FMT_TAG: begin
							if (fs_sh != wavp_pkg::TAG_FMT) begin
								err_hit  = 1'b1;
								err_code = wavp_pkg::ERR_NO_FMT;
							end else begin
								phase_n = PH_FMT_SIZE;
							end
						end
						PH_RIFF_SIZE: phase_n = PH_WAVE_TAG;
						PH_FMT_SIZE: begin
							skip_n  = fs_sh;
							phase_n = PH_FMT_BODY;
						end
						PH_CHUNK_ID: begin
							phase_n = (fs_sh == wavp_pkg::TAG_DATA) ? PH_DATA_SIZE
							                                        : PH_OTHER_SIZE;
						end
						PH_OTHER_SIZE: begin
							skip_n  = fs_sh;
							phase_n = (fs_sh != 32'd0) ? PH_CHUNK_SKIP : PH_CHUNK_ID;
						end
						default: begin
							// data chunk size
							desc_hit = 1'b1;
							left_n   = whole;
							phase_n  = (whole != 32'd0) ? PH_DATA : PH_DONE;
						end
					endcase
				end
			end
			PH_FMT_BODY: begin
				shift_n = fs_sh;
				idx_n   = idx_inc;
				case (idx)
					4'd1: begin
						if (hi_word != 16'd1) begin
							err_hit  = 1'b1;
							err_code = wavp_pkg::ERR_FORMAT;
						end
					end
					4'd3: begin
						if (hi_word != 16'd1 && hi_word != 16'd2) begin
							err_hit  = 1'b1;
							err_code = wavp_pkg::ERR_CHANNELS;
						end else begin
							stereo_n = (hi_word == 16'd2);
						end
					end
					4'd7: rate_n = fs_sh;
					4'd15: begin
						if (hi_word != 16'd8 && hi_word != 16'd16) begin
							err_hit  = 1'b1;
							err_code = wavp_pkg::ERR_BITS;
						end else if (fs_sh[15:0] != exp_align) begin
							err_hit  = 1'b1;
							err_code = wavp_pkg::ERR_ALIGN;
						end else begin
							wide_n  = (hi_word == 16'd16);
							idx_n   = 4'd0;
							skip_n  = (skip > wavp_pkg::FMT_STD_LEN) ?
							          skip - wavp_pkg::FMT_STD_LEN : 32'd0;
							phase_n = (skip > wavp_pkg::FMT_STD_LEN) ? PH_FMT_SKIP
							                                         : PH_CHUNK_ID;
						end
					end
					default: ;
				endcase
			end
			PH_FMT_SKIP, PH_CHUNK_SKIP: begin
				skip_n = skip_dec;
				if (skip_dec == 32'd0) begin
					phase_n = PH_CHUNK_ID;
				end
			end
			PH_DATA: begin
				left_n    = left_dec;
				data_hit  = 1'b1;
				data_last = (left_dec == 32'd0) || end_of_file;
				if (left_dec == 32'd0) begin
					phase_n = PH_DONE;
				end
			end
			default: ;
		endcase

		if (err_hit) begin
			phase_n = PH_IDLE;
		end

		// end of file: a header cut short is an error, then wait for a new file
		if (end_of_file) begin
			if (!err_hit && !desc_hit && !data_hit && phase_n != PH_IDLE &&
			    phase_n != PH_DONE && phase_n != PH_DATA) begin
				err_hit  = 1'b1;
				err_code = wavp_pkg::ERR_NO_DATA;
			end
			phase_n = PH_IDLE;
		end

		result              = '0;
		result.valid        = take && (err_hit || desc_hit || data_hit);
		if (err_hit) begin
			result.kind     = wavp_pkg::KIND_ERROR;
			result.err_code = err_code;
		end else if (desc_hit) begin
			result.kind         = wavp_pkg::KIND_DESC;
			result.sample_type  = {stereo, wide};
			result.rate_hz      = rate;
			result.frames_total = frames;
		end else begin
			result.kind        = wavp_pkg::KIND_DATA;
			result.sample_byte = data_hit ? data_byte : 8'd0;
			result.last_data   = data_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			idx_q    <= 4'd0;
			shift_q  <= 32'd0;
			skip_q   <= 32'd0;
			stereo_q <= 1'b0;
			wide_q   <= 1'b0;
			rate_q   <= 32'd0;
			left_q   <= 32'd0;
		end else if (take) begin
			phase_q  <= phase_n;
			idx_q    <= idx_n;
			shift_q  <= shift_n;
			skip_q   <= skip_n;
			stereo_q <= stereo_n;
			wide_q   <= wide_n;
			rate_q   <= rate_n;
			left_q   <= left_n;
		end
	end

endmodule

@@ rtl/core/wavp_out_fifo.sv @@
// two-entry result buffer between the parser and the output channel
// depends on wavp_pkg
module wavp_out_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  wavp_pkg::wavp_result_t push,
	input  logic                   pop,
	output wavp_pkg::wavp_result_t head,
	output wavp_pkg::wavp_buf_stat_t stat
);

	wavp_pkg::wavp_result_t mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign do_push    = push.valid;
	assign do_pop     = pop && (count_q != 2'd0);
	assign head       = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == 2'd2);
	assign stat.empty = (count_q == 2'd0);

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: ;
			endcase
		end
	end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// self-checking bench for wav_header_parser_stream: whole, broken and cut wav files
// as byte streams, checked against a byte-level parser model in this file
// depends on wavp_pkg and the rtl under rtl/core
module testbench;

	localparam int RANDOM_BYTES = 40;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int LONG_HOLD    = 300;
	localparam int SETTLE       = 8;
	localparam int HOLD_AT      = 40;

	// parser phases, one per header field or chunk region
	typedef enum logic [3:0] {
		P_IDLE, P_RIFF_TAG, P_RIFF_LEN, P_WAVE_TAG, P_FMT_TAG, P_FMT_LEN, P_FMT_BODY,
		P_FMT_SKIP, P_CHUNK_ID, P_DATA_LEN, P_OTHER_LEN, P_CHUNK_SKIP, P_DATA, P_DONE
	} parse_phase_e;

	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  err_code;
		logic [1:0]  sample_type;
		logic [31:0] rate_hz;
		logic [31:0] frames_total;
		logic [7:0]  sample_byte;
		logic        last_data;
	} wav_result_t;

	typedef struct packed {
		logic [7:0] data;
		logic       sof;
		logic       eof;
		logic       drain;  // sender waits for all results before offering this byte
	} file_byte_t;

	// recipe for one file image
	typedef struct packed {
		logic [15:0] fmt_code;
		logic [15:0] chans;
		logic [15:0] align;
		logic [15:0] bits;
		logic [31:0] rate;
		logic [31:0] fmt_size;
		logic [31:0] data_size;
		int          junk_len;    // size of one foreign chunk ahead of data, -1 for none
		int          data_count;  // data bytes actually written
		int          tail_len;    // bytes after the data chunk
		int          bad_pos;     // byte to corrupt, -1 for none
		logic [7:0]  bad_xor;
		int          cut_at;      // last byte sent, -1 for the whole image
		bit          open_end;    // no end of file marker, next file restarts the parser
	} wav_spec_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [7:0] s_tdata;
	logic s_tuser;
	logic s_tlast;
	logic m_tvalid;
	logic m_tready;
	logic [wavp_pkg::TDATA_W-1:0] m_tdata;
	logic [1:0] m_tuser;
	logic m_tlast;

	wav_header_parser_stream dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #1 clk = ~clk;

	// stimulus and scoreboard storage
	file_byte_t  file_stream[$];
	wav_result_t predicted_results[$];
	logic [7:0]  image[$];

	int bytes_offered = 0;
	int bytes_taken = 0;
	int results_taken = 0;
	int mismatches = 0;
	int cycle_count = 0;
	int hold_at = 0;

	// parser model state
	parse_phase_e hdr_phase;
	logic [4:0]   hdr_index;
	logic [31:0]  hdr_word;
	logic [31:0]  hdr_skip;
	logic [1:0]   hdr_chans;
	logic [4:0]   hdr_bits;
	logic [31:0]  hdr_rate;
	logic [31:0]  hdr_left;

	function automatic void clear_header();
		hdr_index = '0;
		hdr_word = '0;
		hdr_skip = '0;
		hdr_chans = '0;
		hdr_bits = '0;
		hdr_rate = '0;
		hdr_left = '0;
	endfunction

	// shift a byte into the little-endian word, high when four bytes are in
	function automatic bit shift_in(input logic [7:0] b);
		hdr_word = {b, hdr_word[31:8]};
		hdr_index = hdr_index + 5'd1;
		if (hdr_index >= 5'd4) begin
			hdr_index = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// advance the parser model by one file byte; high when a result is due
	function automatic bit parse_byte(input logic [7:0] b, input logic sof, input logic eof,
			output wav_result_t r);
		bit          hit;
		bit          fault;
		bit          fmt_end;
		logic [2:0]  fault_code;
		logic [15:0] hi16;
		logic [15:0] lo16;
		logic [31:0] blk;
		logic [31:0] nfr;
		r = '0;
		hit = 1'b0;
		fault = 1'b0;
		fault_code = wavp_pkg::ERR_NOT_RIFF;
		if (sof) begin
			clear_header();
			hdr_phase = P_RIFF_TAG;
		end
		case (hdr_phase)
			P_RIFF_TAG: if (shift_in(b)) begin
				if (hdr_word != wavp_pkg::TAG_RIFF) begin
					fault = 1'b1;
					fault_code = wavp_pkg::ERR_NOT_RIFF;
				end else hdr_phase = P_RIFF_LEN;
			end
			P_RIFF_LEN: if (shift_in(b)) hdr_phase = P_WAVE_TAG;
			P_WAVE_TAG: if (shift_in(b)) begin
				if (hdr_word != wavp_pkg::TAG_WAVE) begin
					fault = 1'b1;
					fault_code = wavp_pkg::ERR_NOT_WAVE;
				end else hdr_phase = P_FMT_TAG;
			end
			P_FMT_TAG: if (shift_in(b)) begin
				if (hdr_word != wavp_pkg::TAG_FMT) begin
					fault = 1'b1;
					fault_code = wavp_pkg::ERR_NO_FMT;
				end else hdr_phase = P_FMT_LEN;
			end
			P_FMT_LEN: if (shift_in(b)) begin
				hdr_skip = hdr_word;
				hdr_phase = P_FMT_BODY;
			end
			P_FMT_BODY: begin
				hdr_word = {b, hdr_word[31:8]};
				hi16 = hdr_word[31:16];
				lo16 = hdr_word[15:0];
				fmt_end = (hdr_index == 5'd15);
				if (hdr_index == 5'd1) begin
					if (hi16 != 16'd1) begin
						fault = 1'b1;
						fault_code = wavp_pkg::ERR_FORMAT;
					end
				end else if (hdr_index == 5'd3) begin
					if (hi16 != 16'd1 && hi16 != 16'd2) begin
						fault = 1'b1;
						fault_code = wavp_pkg::ERR_CHANNELS;
					end else hdr_chans = hi16[1:0];
				end else if (hdr_index == 5'd7) begin
					hdr_rate = hdr_word;
				end else if (fmt_end) begin
					// bits are checked ahead of block align
					if (hi16 != 16'd8 && hi16 != 16'd16) begin
						fault = 1'b1;
						fault_code = wavp_pkg::ERR_BITS;
					end else if ({16'd0, lo16} != {30'd0, hdr_chans} * ({16'd0, hi16} >> 3)) begin
						fault = 1'b1;
						fault_code = wavp_pkg::ERR_ALIGN;
					end else begin
						hdr_bits = hi16[4:0];
						hdr_index = '0;
						hdr_skip = (hdr_skip > wavp_pkg::FMT_STD_LEN) ?
							hdr_skip - wavp_pkg::FMT_STD_LEN : '0;
						hdr_phase = (hdr_skip != 0) ? P_FMT_SKIP : P_CHUNK_ID;
					end
				end
				if (!fault && !fmt_end) hdr_index = hdr_index + 5'd1;
			end
			P_FMT_SKIP, P_CHUNK_SKIP: begin
				hdr_skip = hdr_skip - 32'd1;
				if (hdr_skip == 0) hdr_phase = P_CHUNK_ID;
			end
			P_CHUNK_ID: if (shift_in(b)) begin
				hdr_phase = (hdr_word == wavp_pkg::TAG_DATA) ? P_DATA_LEN : P_OTHER_LEN;
			end
			P_OTHER_LEN: if (shift_in(b)) begin
				hdr_skip = hdr_word;
				hdr_phase = (hdr_skip != 0) ? P_CHUNK_SKIP : P_CHUNK_ID;
			end
			P_DATA_LEN: if (shift_in(b)) begin
				blk = {30'd0, hdr_chans} * {27'd0, hdr_bits >> 3};
				nfr = (blk != 0) ? hdr_word / blk : '0;
				hdr_left = nfr * blk;
				r.kind = wavp_pkg::KIND_DESC;
				r.sample_type = {hdr_chans == 2'd2, hdr_bits == 5'd16};
				r.rate_hz = hdr_rate;
				r.frames_total = nfr;
				hit = 1'b1;
				hdr_phase = (hdr_left != 0) ? P_DATA : P_DONE;
			end
			P_DATA: begin
				hdr_left = hdr_left - 32'd1;
				r.kind = wavp_pkg::KIND_DATA;
				r.sample_byte = b;
				r.last_data = (hdr_left == 0) || eof;
				hit = 1'b1;
				if (hdr_left == 0) hdr_phase = P_DONE;
			end
			default: ;
		endcase
		if (fault) begin
			r = '0;
			r.kind = wavp_pkg::KIND_ERROR;
			r.err_code = fault_code;
			hit = 1'b1;
			hdr_phase = P_IDLE;
		end
		// end of file ahead of the descriptor is an error unless this byte already made one
		if (eof) begin
			if (!hit && hdr_phase != P_IDLE && hdr_phase != P_DONE && hdr_phase != P_DATA) begin
				r = '0;
				r.kind = wavp_pkg::KIND_ERROR;
				r.err_code = wavp_pkg::ERR_NO_DATA;
				hit = 1'b1;
			end
			hdr_phase = P_IDLE;
		end
		return hit;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	// image building
	task automatic put_word(input logic [31:0] v);
		for (int i = 0; i < 4; i++) image.push_back(v[8*i +: 8]);
	endtask

	task automatic put_half(input logic [15:0] v);
		image.push_back(v[7:0]);
		image.push_back(v[15:8]);
	endtask

	task automatic put_random(input int count);
		logic [7:0] v;
		repeat (count) begin
			v = 8'($urandom_range(0, 255));
			image.push_back(v);
		end
	endtask

	// bytes with no start of file ahead of them, dropped by an idle parser
	task automatic push_noise(input int count);
		file_byte_t fb;
		repeat (count) begin
			fb.data = 8'($urandom_range(0, 255));
			fb.sof = 1'b0;
			fb.eof = 1'($urandom_range(0, 1));
			fb.drain = 1'b0;
			file_stream.push_back(fb);
		end
	endtask

	function automatic wav_spec_t good_spec(input int chans, input int bits, input int frames);
		wav_spec_t s;
		s.fmt_code = 16'd1;
		s.chans = 16'(chans);
		s.bits = 16'(bits);
		s.align = 16'(chans * bits / 8);
		s.rate = $urandom;
		s.fmt_size = 32'd16;
		s.data_size = 32'(frames) * {16'd0, s.align};
		s.junk_len = -1;
		s.data_count = int'(s.data_size);
		s.tail_len = 0;
		s.bad_pos = -1;
		s.bad_xor = '0;
		s.cut_at = -1;
		s.open_end = 1'b0;
		return s;
	endfunction

	// build the image of one file and queue it; returns the number of bytes queued
	task automatic send_file(input wav_spec_t s, input bit drain, output int sent);
		logic [31:0] tag;
		file_byte_t  fb;
		int          last;
		image.delete();
		put_word(wavp_pkg::TAG_RIFF);
		put_word(32'd36 + s.data_size);
		put_word(wavp_pkg::TAG_WAVE);
		put_word(wavp_pkg::TAG_FMT);
		put_word(s.fmt_size);
		put_half(s.fmt_code);
		put_half(s.chans);
		put_word(s.rate);
		put_word(s.rate * {16'd0, s.align});
		put_half(s.align);
		put_half(s.bits);
		if (s.fmt_size > 32'd16) put_random(int'(s.fmt_size - 32'd16));
		if (s.junk_len >= 0) begin
			tag = $urandom;
			if (tag == wavp_pkg::TAG_DATA) tag = tag ^ 32'h1;
			put_word(tag);
			put_word(32'(s.junk_len));
			put_random(s.junk_len);
		end
		put_word(wavp_pkg::TAG_DATA);
		put_word(s.data_size);
		put_random(s.data_count);
		put_random(s.tail_len);
		if (s.bad_pos >= 0 && s.bad_pos < image.size())
			image[s.bad_pos] = image[s.bad_pos] ^ s.bad_xor;
		last = (s.cut_at >= 0 && s.cut_at < image.size()) ? s.cut_at : image.size() - 1;
		for (int i = 0; i <= last; i++) begin
			fb.data = image[i];
			fb.sof = (i == 0);
			fb.eof = (i == last) && !s.open_end;
			fb.drain = (i == 0) && drain;
			file_stream.push_back(fb);
		end
		sent = last + 1;
	endtask

	// scoreboard: predict on every input transaction, compare on every output transaction
	always @(posedge clk) begin
		wav_result_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				bytes_taken++;
				if (parse_byte(s_tdata, s_tuser, s_tlast, want)) predicted_results.push_back(want);
			end
			if (m_tvalid && m_tready) begin
				results_taken++;
				if (predicted_results.size() == 0) begin
					$error("result of kind %0d with none expected", m_tuser);
					mismatches++;
				end else begin
					want = predicted_results.pop_front();
					check_field("result_kind", 32'(want.kind), 32'(m_tuser));
					check_field("error_code", 32'(want.err_code), 32'(m_tdata[2:0]));
					check_field("sample_type", 32'(want.sample_type), 32'(m_tdata[4:3]));
					check_field("rate_hz", want.rate_hz, m_tdata[36:5]);
					check_field("frames_total", want.frames_total, m_tdata[68:37]);
					check_field("sample_byte", 32'(want.sample_byte), 32'(m_tdata[76:69]));
					check_field("last_data", 32'(want.last_data), 32'(m_tlast));
				end
			end
		end
	end

	// byte driver: random gap ahead of each byte, runs of back-to-back bytes,
	// and a pause until the results are all in where a byte asks for it
	file_byte_t cur_byte = '0;
	int  send_gap = 0;
	bit  send_burst = 1'b0;

	always @(negedge clk) begin
		if (arst_n) begin
			if (bytes_offered == bytes_taken) begin
				if (send_gap != 0) begin
					send_gap--;
				end else if (file_stream.size() != 0 &&
						!(file_stream[0].drain && predicted_results.size() != 0)) begin
					cur_byte = file_stream.pop_front();
					bytes_offered++;
					if ($urandom_range(0, 19) == 0) send_burst = !send_burst;
					send_gap = send_burst ? 0 : $urandom_range(0, 9);
				end
			end
			s_tvalid <= (bytes_offered != bytes_taken);
			s_tdata <= cur_byte.data;
			s_tuser <= cur_byte.sof;
			s_tlast <= cur_byte.eof;
		end
	end

	// result receiver: random stall after each result, plus one long hold-off
	// that fills the result buffer and backs up the input
	int  results_seen = 0;
	int  recv_gap = 0;
	int  hold_left = 0;
	bit  hold_done = 1'b0;
	bit  recv_burst = 1'b0;

	always @(negedge clk) begin
		if (arst_n) begin
			if (results_taken != results_seen) begin
				results_seen = results_taken;
				if ($urandom_range(0, 19) == 0) recv_burst = !recv_burst;
				recv_gap = recv_burst ? 0 : $urandom_range(0, 9);
			end
			if (!hold_done && bytes_taken >= hold_at) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (recv_gap != 0) begin
				recv_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[wav_header_parser_stream] ERROR");
			$finish;
		end
	end

	initial begin
		wav_spec_t spec;
		int        sent;
		int        random_sent;
		int        pick;
		bit        mid_drain;
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		hdr_phase = P_IDLE;
		clear_header();
		// long hold-off starts at the data chunk header of the first file, just ahead of its data, where results come dense
		hold_at = HOLD_AT;

		// directed files
		// bytes ahead of any start of file
		push_noise(3);
		// u8 mono, plain layout
		spec = good_spec(1, 8, 5);
		spec.rate = 32'd8000;
		send_file(spec, 1'b0, sent);
		// s16 stereo, top rate, long fmt, odd foreign chunk, partial frame, trailing bytes
		spec = good_spec(2, 16, 2);
		spec.rate = '1;
		spec.fmt_size = 32'd18;
		spec.junk_len = 3;
		spec.data_size = 32'd9;
		spec.data_count = 9;
		spec.tail_len = 4;
		send_file(spec, 1'b0, sent);
		// s16 mono, zero rate, short fmt, empty data chunk followed by junk
		spec = good_spec(1, 16, 0);
		spec.rate = '0;
		spec.fmt_size = '0;
		spec.tail_len = 5;
		send_file(spec, 1'b0, sent);
		// u8 stereo, largest data size, end of file inside the data
		spec = good_spec(2, 8, 0);
		spec.data_size = '1;
		spec.data_count = 6;
		send_file(spec, 1'b0, sent);
		// broken tags
		spec = good_spec(1, 8, 2);
		spec.bad_pos = 0;
		spec.bad_xor = 8'hff;
		send_file(spec, 1'b0, sent);
		spec.bad_pos = 11;
		send_file(spec, 1'b0, sent);
		spec.bad_pos = 14;
		send_file(spec, 1'b0, sent);
		// bad format, channels, bits (align wrong too, bits wins), align
		spec = good_spec(1, 8, 2);
		spec.fmt_code = '0;
		send_file(spec, 1'b0, sent);
		spec = good_spec(1, 8, 2);
		spec.chans = '1;
		send_file(spec, 1'b0, sent);
		spec = good_spec(1, 8, 2);
		spec.bits = 16'd24;
		send_file(spec, 1'b0, sent);
		spec = good_spec(2, 16, 1);
		spec.align = 16'd2;
		send_file(spec, 1'b0, sent);
		// end of file inside a skipped chunk
		spec = good_spec(1, 8, 2);
		spec.junk_len = 40;
		spec.cut_at = 50;
		send_file(spec, 1'b0, sent);
		// end of file on the byte that breaks the riff tag
		spec = good_spec(1, 8, 2);
		spec.bad_pos = 3;
		spec.bad_xor = 8'h01;
		spec.cut_at = 3;
		send_file(spec, 1'b0, sent);
		// one-byte file, start and end on the same byte
		spec = good_spec(1, 8, 2);
		spec.cut_at = 0;
		send_file(spec, 1'b0, sent);
		// new start of file in the middle of the fmt chunk
		spec = good_spec(1, 16, 2);
		spec.cut_at = 20;
		spec.open_end = 1'b1;
		send_file(spec, 1'b0, sent);
		spec = good_spec(2, 16, 3);
		send_file(spec, 1'b0, sent);

		// random files, mostly well formed, the first one after a full drain
		random_sent = 0;
		mid_drain = 1'b0;
		while (random_sent < RANDOM_BYTES) begin
			spec = good_spec($urandom_range(1, 2), 8 * $urandom_range(1, 2), $urandom_range(0, 8));
			pick = $urandom_range(0, 9);
			if (pick < 2) spec.fmt_size = $urandom_range(0, 15);
			else if (pick < 4) spec.fmt_size = $urandom_range(17, 21);
			if ($urandom_range(0, 1) != 0) spec.junk_len = $urandom_range(0, 7);
			if ($urandom_range(0, 3) == 0) spec.data_size = spec.data_size + $urandom_range(1, 3);
			spec.data_count = int'(spec.data_size);
			if ($urandom_range(0, 3) == 0) spec.tail_len = $urandom_range(1, 6);
			pick = $urandom_range(0, 99);
			if (pick < 12) begin
				spec.bad_pos = $urandom_range(0, 35);
				spec.bad_xor = 8'($urandom_range(1, 255));
			end else if (pick < 18) begin
				spec.cut_at = $urandom_range(0, 60);
			end else if (pick < 21) begin
				while (spec.fmt_code == 16'd1) spec.fmt_code = 16'($urandom_range(0, 65535));
			end else if (pick < 24) begin
				while (spec.chans == 16'd1 || spec.chans == 16'd2)
					spec.chans = 16'($urandom_range(0, 65535));
			end else if (pick < 27) begin
				while (spec.bits == 16'd8 || spec.bits == 16'd16)
					spec.bits = 16'($urandom_range(0, 65535));
			end else if (pick < 30) begin
				spec.align = spec.align ^ 16'($urandom_range(1, 65535));
			end else if (pick < 34) begin
				spec.cut_at = $urandom_range(0, 60);
				spec.open_end = 1'b1;
			end else if (pick < 40) begin
				// end of file inside the data, or right at its start or its end
				spec.data_count = int'($urandom_range(0, spec.data_size));
			end
			send_file(spec, random_sent == 0 || (!mid_drain && random_sent >= RANDOM_BYTES / 2),
				sent);
			if (random_sent >= RANDOM_BYTES / 2) mid_drain = 1'b1;
			random_sent += sent;
			if (!spec.open_end && $urandom_range(0, 9) == 0) push_noise($urandom_range(1, 4));
		end

		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (file_stream.size() != 0 || bytes_offered != bytes_taken) @(posedge clk);
		while (predicted_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && predicted_results.size() == 0) begin
			$display("[wav_header_parser_stream] OK");
		end else begin
			$display("[wav_header_parser_stream] ERROR");
		end
		$finish;
	end

endmodule

@@ wav_header_parser_stream.f @@
rtl/core/wavp_pkg.sv
rtl/core/wavp_parser.sv
rtl/core/wavp_out_fifo.sv
rtl/core/wav_header_parser_stream.sv
bench/testbench.sv
